// ===== src/sgr_pkg.sv =====
// Shared types, constants and font ROM for the scaled glyph rasterizer.
package sgr_pkg;

  localparam int SCREEN_W  = 240;
  localparam int SCREEN_H  = 320;
  localparam int MAX_SCALE = 8;

  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
  localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);
  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // latch a new character word
    logic emit;  // produce the current cell into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;  // current cell is the final one of the glyph
  } status_t;

  // Pack five 7-bit columns; column 0 in the low bits, row 0 lowest in a column.
  function automatic logic [GLYPH_BITS-1:0] g5(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2, input logic [7:0] c3,
                                               input logic [7:0] c4);
    g5 = {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
  endfunction

  // Font ROM, lower case folded to upper case; unknown codes are blank.
  function automatic logic [GLYPH_BITS-1:0] glyph_cols(input logic [7:0] code_in);
    logic [7:0] code;
    code = code_in;
    if (code >= 8'h61 && code <= 8'h7a) code = code - 8'h20;
    case (code)
      8'h30: glyph_cols = g5(8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e);
      8'h31: glyph_cols = g5(8'h00, 8'h42, 8'h7f, 8'h40, 8'h00);
      8'h32: glyph_cols = g5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33: glyph_cols = g5(8'h21, 8'h41, 8'h45, 8'h4b, 8'h31);
      8'h34: glyph_cols = g5(8'h18, 8'h14, 8'h12, 8'h7f, 8'h10);
      8'h35: glyph_cols = g5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36: glyph_cols = g5(8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30);
      8'h37: glyph_cols = g5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'h38: glyph_cols = g5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: glyph_cols = g5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1e);
      8'h41: glyph_cols = g5(8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e);
      8'h42: glyph_cols = g5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h43: glyph_cols = g5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h44: glyph_cols = g5(8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c);
      8'h45: glyph_cols = g5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h46: glyph_cols = g5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h01);
      8'h47: glyph_cols = g5(8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a);
      8'h48: glyph_cols = g5(8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f);
      8'h49: glyph_cols = g5(8'h00, 8'h41, 8'h7f, 8'h41, 8'h00);
      8'h4a: glyph_cols = g5(8'h20, 8'h40, 8'h41, 8'h3f, 8'h01);
      8'h4b: glyph_cols = g5(8'h7f, 8'h08, 8'h14, 8'h22, 8'h41);
      8'h4c: glyph_cols = g5(8'h7f, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4d: glyph_cols = g5(8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f);
      8'h4e: glyph_cols = g5(8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f);
      8'h4f: glyph_cols = g5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e);
      8'h50: glyph_cols = g5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h51: glyph_cols = g5(8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e);
      8'h52: glyph_cols = g5(8'h7f, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53: glyph_cols = g5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'h54: glyph_cols = g5(8'h01, 8'h01, 8'h7f, 8'h01, 8'h01);
      8'h55: glyph_cols = g5(8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f);
      8'h56: glyph_cols = g5(8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f);
      8'h57: glyph_cols = g5(8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f);
      8'h58: glyph_cols = g5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      8'h59: glyph_cols = g5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      8'h5a: glyph_cols = g5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      8'h2d: glyph_cols = g5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);  // dash
      8'h2e: glyph_cols = g5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);  // dot
      8'h3a: glyph_cols = g5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);  // colon
      8'h2f: glyph_cols = g5(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);  // slash
      8'h25: glyph_cols = g5(8'h62, 8'h64, 8'h08, 8'h13, 8'h23);  // percent
      8'h3d: glyph_cols = g5(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);  // equals
      default: glyph_cols = '0;
    endcase
  endfunction

  // RGB888 -> RGB565, bytes swapped for the panel.
  function automatic logic [15:0] pack_color(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = {r[7:3], g[7:2], b[7:3]};
    pack_color = {c[7:0], c[15:8]};
  endfunction

endpackage

// ===== src/sgr_ctrl.sv =====
// Controller state machine: input handshake, cell sequencing, output valid.
module sgr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sgr_pkg::status_t  status,
  output sgr_pkg::cmd_t     cmd
);

  sgr_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_free  = !out_valid_r || out_ready;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    case (state_r)
      sgr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_nxt = sgr_pkg::ST_RUN;
      end
      sgr_pkg::ST_RUN: begin
        cmd.emit = out_free;
        if (out_free && status.last) state_nxt = sgr_pkg::ST_IDLE;
      end
      default: state_nxt = sgr_pkg::ST_IDLE;
    endcase
    // output word register: filled on emit, drained when taken
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/sgr_datapath.sv =====
// Datapath: held glyph and origin, cell walk, clipping, output word register.
module sgr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sgr_pkg::cmd_t       cmd,
  output sgr_pkg::status_t    status,
  input  logic [7:0]          in_char_code,
  input  logic signed [10:0]  in_origin_x,
  input  logic signed [10:0]  in_origin_y,
  input  logic [3:0]          in_scale,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic [7:0]          out_rect_x,
  output logic [8:0]          out_rect_y,
  output logic [3:0]          out_rect_width,
  output logic [3:0]          out_rect_height,
  output logic [15:0]         out_pixel_color,
  output logic                out_visible,
  output logic                out_last_cell
);

  localparam logic signed [13:0] SCR_W = 14'(sgr_pkg::SCREEN_W);
  localparam logic signed [13:0] SCR_H = 14'(sgr_pkg::SCREEN_H);

  logic [sgr_pkg::GLYPH_BITS-1:0] glyph_r;
  logic signed [11:0] cur_x_r, cur_y_r, org_y_r;
  logic [3:0]  scale_r;
  logic [15:0] color_r;
  logic [2:0]  row_r, col_r;

  logic [7:0]  rect_x_r;
  logic [8:0]  rect_y_r;
  logic [3:0]  rect_w_r, rect_h_r;
  logic [15:0] pix_r;
  logic        vis_r, last_r;

  logic [3:0]         scale_sat;
  logic signed [13:0] sv, cx, cy, cw, ch;
  logic               cell_on;

  assign scale_sat   = (in_scale > 4'(sgr_pkg::MAX_SCALE)) ? 4'(sgr_pkg::MAX_SCALE) : in_scale;
  assign status.last = (col_r == sgr_pkg::LAST_COL) && (row_r == sgr_pkg::LAST_ROW);

  // clip the current cell against the screen
  always_comb begin
    sv = signed'({10'd0, scale_r});
    cx = 14'(cur_x_r);
    cy = 14'(cur_y_r);
    cw = sv;
    ch = sv;
    if (cx < 0) begin
      cw = sv + cx;
      cx = '0;
    end
    if (cy < 0) begin
      ch = sv + cy;
      cy = '0;
    end
    if (cx + cw > SCR_W) cw = SCR_W - cx;
    if (cy + ch > SCR_H) ch = SCR_H - cy;
    cell_on = glyph_r[0] && (cw > 0) && (ch > 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.load) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.emit) begin
      if (row_r == sgr_pkg::LAST_ROW) begin
        row_r <= '0;
        col_r <= col_r + 3'd1;
      end else begin
        row_r <= row_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph_r <= sgr_pkg::glyph_cols(in_char_code);
      cur_x_r <= 12'(in_origin_x);
      cur_y_r <= 12'(in_origin_y);
      org_y_r <= 12'(in_origin_y);
      scale_r <= scale_sat;
      color_r <= sgr_pkg::pack_color(in_red, in_green, in_blue);
    end else if (cmd.emit) begin
      glyph_r <= glyph_r >> 1;
      if (row_r == sgr_pkg::LAST_ROW) begin
        cur_y_r <= org_y_r;
        cur_x_r <= cur_x_r + signed'({8'd0, scale_r});
      end else begin
        cur_y_r <= cur_y_r + signed'({8'd0, scale_r});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rect_x_r <= cell_on ? cx[7:0] : '0;
      rect_y_r <= cell_on ? cy[8:0] : '0;
      rect_w_r <= cell_on ? cw[3:0] : '0;
      rect_h_r <= cell_on ? ch[3:0] : '0;
      pix_r    <= color_r;
      vis_r    <= cell_on;
      last_r   <= status.last;
    end
  end

  assign out_rect_x      = rect_x_r;
  assign out_rect_y      = rect_y_r;
  assign out_rect_width  = rect_w_r;
  assign out_rect_height = rect_h_r;
  assign out_pixel_color = pix_r;
  assign out_visible     = vis_r;
  assign out_last_cell   = last_r;

endmodule

// ===== src/scaled_glyph_rasterizer.sv =====
// Top level of the scaled glyph rasterizer: controller plus datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per character: code, signed
//   origin, scale (saturated to 8) and an RGB888 color.
//   Output channel (out_valid/out_ready): 35 words per character, one per
//   glyph cell, columns 0..4 and rows 0..6 within a column. Each word is the
//   cell rectangle clipped to the 240x320 screen, the byte-swapped RGB565
//   color, a visible flag and last_cell on the final cell.
// Timing:
//   The first cell word reaches the output register after the sequencer has
//   entered its run state; then one cell per cycle while out_ready stays high.
//   Each character is one accept step in the idle state plus the 35-cell walk
//   of the sequencer. in_ready is high whenever no character is in flight,
//   even while the final cell word still sits in the output register.
// Stalls: a low out_ready freezes the cell walk; the output word holds.
// Reset (rst_n low, synchronous): sequencer idle, no output word valid.
module scaled_glyph_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic signed [10:0] in_origin_x,
  input  logic signed [10:0] in_origin_y,
  input  logic [3:0]         in_scale,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_rect_x,
  output logic [8:0]         out_rect_y,
  output logic [3:0]         out_rect_width,
  output logic [3:0]         out_rect_height,
  output logic [15:0]        out_pixel_color,
  output logic               out_visible,
  output logic               out_last_cell
);

  sgr_pkg::cmd_t    cmd;
  sgr_pkg::status_t status;

  // sequencer: accepts characters, steps cells, owns output valid
  sgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // glyph lookup, cell geometry, clipping and output word register
  sgr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_char_code    (in_char_code),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_scale        (in_scale),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_pixel_color (out_pixel_color),
    .out_visible     (out_visible),
    .out_last_cell   (out_last_cell)
  );

endmodule

// ===== bench/tb_scaled_glyph_rasterizer.sv =====
// Self-checking testbench for scaled_glyph_rasterizer: directed table plus random characters.
`timescale 1ns / 1ps

module tb_scaled_glyph_rasterizer;

  localparam int RANDOM_CHARS = 205;
  localparam int DRAIN_CYCLES = 8;  // extra idle clocks after the last expected cell word is taken

  // How a table row is checked: against the predictor, or against a typed-in
  // all-blank glyph whose color is given in the row.
  typedef enum logic [0:0] {
    ROW_PREDICT,
    ROW_BLANK
  } row_check_t;

  typedef struct {
    logic [7:0]         code;
    logic signed [10:0] ox;
    logic signed [10:0] oy;
    logic [3:0]         scale;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    row_check_t         chk;
    logic [15:0]        color;  // typed color word, ROW_BLANK rows only
  } glyph_case_t;

  typedef struct {
    logic [7:0]  x;
    logic [8:0]  y;
    logic [3:0]  w;
    logic [3:0]  h;
    logic [15:0] color;
    logic        vis;
    logic        last;
  } cell_word_t;

  // Font columns, column 0 in the top byte, row 0 in bit 0 of each byte.
  localparam logic [0:9][39:0] DIGIT_ROM = {
    40'h3e_51_49_45_3e, 40'h00_42_7f_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4b_31,
    40'h18_14_12_7f_10, 40'h27_45_45_45_39, 40'h3c_4a_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1e};

  localparam logic [0:25][39:0] LETTER_ROM = {
    40'h7e_11_11_11_7e, 40'h7f_49_49_49_36, 40'h3e_41_41_41_22, 40'h7f_41_41_22_1c,
    40'h7f_49_49_49_41, 40'h7f_09_09_09_01, 40'h3e_41_49_49_7a, 40'h7f_08_08_08_7f,
    40'h00_41_7f_41_00, 40'h20_40_41_3f_01, 40'h7f_08_14_22_41, 40'h7f_40_40_40_40,
    40'h7f_02_0c_02_7f, 40'h7f_04_08_10_7f, 40'h3e_41_41_41_3e, 40'h7f_09_09_09_06,
    40'h3e_41_51_21_5e, 40'h7f_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7f_01_01,
    40'h3f_40_40_40_3f, 40'h1f_20_40_20_1f, 40'h3f_40_38_40_3f, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h61_51_49_45_43};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_char_code;
  logic signed [10:0] in_origin_x;
  logic signed [10:0] in_origin_y;
  logic [3:0]         in_scale;
  logic [7:0]         in_red;
  logic [7:0]         in_green;
  logic [7:0]         in_blue;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_rect_x;
  logic [8:0]         out_rect_y;
  logic [3:0]         out_rect_width;
  logic [3:0]         out_rect_height;
  logic [15:0]        out_pixel_color;
  logic               out_visible;
  logic               out_last_cell;

  cell_word_t pending_cells[$];  // cell words still owed by the DUT, oldest first
  int         mismatches = 0;
  int         cells_seen = 0;
  bit         idle_on = 1'b1;    // random idling on both channels

  // Character set the font knows, both cases; used to bias random codes.
  string glyph_alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-.:/%=";

  // Directed rows. Blank rows carry the color word worked out by hand:
  // RGB565 = {r[7:3], g[7:2], b[7:3]}, then the two bytes swapped.
  glyph_case_t glyph_cases [24] = '{
    '{"A",    0,     0,     1,  8'hff, 8'hff, 8'hff, ROW_PREDICT, 16'h0000},
    '{8'h00,  20,    20,    4,  8'hff, 8'h00, 8'h00, ROW_BLANK,   16'h00f8},  // code zero
    '{8'hff,  20,    20,    4,  8'h00, 8'hff, 8'h00, ROW_BLANK,   16'he007},  // top code
    '{"a",    10,    10,    8,  8'h5a, 8'ha5, 8'h3c, ROW_PREDICT, 16'h0000},  // folds to A
    '{"B",    50,    50,    0,  8'h00, 8'h00, 8'hff, ROW_BLANK,   16'h1f00},  // zero scale
    '{"M",    100,   100,   15, 8'h81, 8'h42, 8'h24, ROW_PREDICT, 16'h0000},  // saturates
    '{"W",    -1024, -1024, 8,  8'h00, 8'h00, 8'h00, ROW_BLANK,   16'h0000},  // far up-left
    '{"8",    1023,  1023,  8,  8'h12, 8'h34, 8'h56, ROW_BLANK,   16'haa11},  // far down-right
    '{"0",    -3,    -5,    4,  8'hf0, 8'h0f, 8'haa, ROW_PREDICT, 16'h0000},  // clip left/top
    '{"H",    236,   316,   8,  8'h11, 8'h22, 8'h33, ROW_PREDICT, 16'h0000},  // clip right/bottom
    '{"-",    0,     312,   1,  8'hff, 8'h00, 8'hff, ROW_PREDICT, 16'h0000},
    '{".",    200,   0,     2,  8'h07, 8'h03, 8'h07, ROW_PREDICT, 16'h0000},
    '{":",    -10,   300,   3,  8'h08, 8'h04, 8'h08, ROW_PREDICT, 16'h0000},
    '{"/",    230,   -20,   5,  8'h80, 8'h80, 8'h80, ROW_PREDICT, 16'h0000},
    '{"%",    120,   160,   6,  8'hc3, 8'h3c, 8'h99, ROW_PREDICT, 16'h0000},
    '{"=",    -1,    -1,    7,  8'h66, 8'h99, 8'hee, ROW_PREDICT, 16'h0000},
    '{"9",    232,   312,   9,  8'h01, 8'h02, 8'h04, ROW_PREDICT, 16'h0000},  // saturates
    '{"z",    5,     5,     8,  8'hfe, 8'hfd, 8'hfb, ROW_PREDICT, 16'h0000},
    '{"Z",    -36,   0,     8,  8'h7f, 8'hbf, 8'hdf, ROW_PREDICT, 16'h0000},  // mostly off left
    '{8'h60,  0,     0,     8,  8'hff, 8'hff, 8'hff, ROW_BLANK,   16'hffff},  // just below a
    '{8'h7b,  0,     0,     8,  8'h80, 8'h80, 8'h80, ROW_BLANK,   16'h1084},  // just above z
    '{8'h40,  0,     0,     1,  8'h00, 8'h00, 8'h00, ROW_BLANK,   16'h0000},  // just below A
    '{8'h5b,  100,   100,   2,  8'h55, 8'haa, 8'h55, ROW_PREDICT, 16'h0000},  // just above Z
    '{8'h80,  10,    10,    1,  8'hff, 8'hff, 8'hff, ROW_BLANK,   16'hffff}   // high bit set
  };

  scaled_glyph_rasterizer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_scale        (in_scale),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_pixel_color (out_pixel_color),
    .out_visible     (out_visible),
    .out_last_cell   (out_last_cell)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // 35 glyph bits, cell n = column n/7, row n%7. Lower case folds to upper.
  function automatic logic [34:0] font_cells(input logic [7:0] code);
    logic [7:0]  up;
    logic [39:0] cols;
    logic [34:0] bits;
    up = code;
    if (up >= "a" && up <= "z") up = up - 8'd32;
    cols = '0;
    if (up >= "0" && up <= "9") cols = DIGIT_ROM[4'(up - "0")];
    else if (up >= "A" && up <= "Z") cols = LETTER_ROM[5'(up - "A")];
    else begin
      case (up)
        "-": cols = 40'h08_08_08_08_08;
        ".": cols = 40'h00_60_60_00_00;
        ":": cols = 40'h00_36_36_00_00;
        "/": cols = 40'h20_10_08_04_02;
        "%": cols = 40'h62_64_08_13_23;
        "=": cols = 40'h14_14_14_14_14;
        default: cols = '0;
      endcase
    end
    for (int c = 0; c < 5; c++) bits[7*c +: 7] = cols[32-8*c +: 7];
    return bits;
  endfunction

  function automatic logic [15:0] swapped_rgb565(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
    logic [15:0] c;
    c = (16'(r & 8'hf8) << 8) | (16'(g & 8'hfc) << 3) | 16'(b >> 3);
    return {c[7:0], c[15:8]};
  endfunction

  // Queue the 35 cell words one character must produce.
  task automatic predict_glyph_cells(input glyph_case_t gc);
    logic [34:0] bits;
    logic [15:0] color;
    cell_word_t  cw;
    int          s, ox, oy, x, y, w, h;
    bit          on;
    bits  = font_cells(gc.code);
    color = swapped_rgb565(gc.red, gc.green, gc.blue);
    s     = (gc.scale > sgr_pkg::MAX_SCALE) ? sgr_pkg::MAX_SCALE : int'(gc.scale);
    ox    = int'(gc.ox);
    oy    = int'(gc.oy);
    for (int n = 0; n < sgr_pkg::GLYPH_BITS; n++) begin
      x = ox + (n / 7) * s;
      y = oy + (n % 7) * s;
      w = s;
      h = s;
      if (x < 0) begin
        w = w + x;
        x = 0;
      end
      if (y < 0) begin
        h = h + y;
        y = 0;
      end
      if (x + w > sgr_pkg::SCREEN_W) w = sgr_pkg::SCREEN_W - x;
      if (y + h > sgr_pkg::SCREEN_H) h = sgr_pkg::SCREEN_H - y;
      on       = bits[n] && w > 0 && h > 0;
      cw.x     = on ? x[7:0] : '0;
      cw.y     = on ? y[8:0] : '0;
      cw.w     = on ? w[3:0] : '0;
      cw.h     = on ? h[3:0] : '0;
      cw.color = color;
      cw.vis   = on;
      cw.last  = (n == sgr_pkg::GLYPH_BITS - 1);
      pending_cells.push_back(cw);
    end
  endtask

  // Typed-in glyph with nothing drawn: zero geometry, only color and last_cell move.
  task automatic queue_blank_glyph(input logic [15:0] color);
    cell_word_t cw;
    for (int n = 0; n < sgr_pkg::GLYPH_BITS; n++) begin
      cw = '{x: '0, y: '0, w: '0, h: '0, color: color, vis: 1'b0,
             last: (n == sgr_pkg::GLYPH_BITS - 1)};
      pending_cells.push_back(cw);
    end
  endtask

  // Present one character word and hold it until taken; queue its cells on accept.
  task automatic send_char(input glyph_case_t gc);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= gc.code;
    in_origin_x  <= gc.ox;
    in_origin_y  <= gc.oy;
    in_scale     <= gc.scale;
    in_red       <= gc.red;
    in_green     <= gc.green;
    in_blue      <= gc.blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gc.chk == ROW_BLANK) queue_blank_glyph(gc.color);
    else predict_glyph_cells(gc);
  endtask

  // Random character: mostly known glyphs placed near the screen, some noise.
  function automatic glyph_case_t random_char();
    glyph_case_t gc;
    if ($urandom_range(0, 9) < 7)
      gc.code = glyph_alphabet[$urandom_range(0, glyph_alphabet.len() - 1)];
    else gc.code = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      gc.ox = 11'($urandom);
      gc.oy = 11'($urandom);
    end else begin
      gc.ox = 11'(int'($urandom_range(0, 271)) - 24);
      gc.oy = 11'(int'($urandom_range(0, 359)) - 24);
    end
    if ($urandom_range(0, 4) == 0) gc.scale = 4'($urandom);
    else gc.scale = 4'($urandom_range(1, sgr_pkg::MAX_SCALE));
    gc.red   = 8'($urandom);
    gc.green = 8'($urandom);
    gc.blue  = 8'($urandom);
    gc.chk   = ROW_PREDICT;
    gc.color = '0;
    return gc;
  endfunction

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("cell %0d %s: got %0d, expected %0d",
                                cells_seen, name, got, want));
  endtask

  // Scoreboard: every accepted cell word against the oldest expectation.
  always @(posedge clk) begin
    cell_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("cell word with none expected: x=%0d y=%0d vis=%0b",
                                  out_rect_x, out_rect_y, out_visible));
      end else begin
        want = pending_cells.pop_front();
        check_field("rect_x", int'(out_rect_x), int'(want.x));
        check_field("rect_y", int'(out_rect_y), int'(want.y));
        check_field("rect_width", int'(out_rect_width), int'(want.w));
        check_field("rect_height", int'(out_rect_height), int'(want.h));
        check_field("pixel_color", int'(out_pixel_color), int'(want.color));
        check_field("visible", int'(out_visible), int'(want.vis));
        check_field("last_cell", int'(out_last_cell), int'(want.last));
      end
      cells_seen++;
    end
  end

  // Receiver: random stall bursts while idling is on.
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Sender and end of run.
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_char_code <= '0;
    in_origin_x  <= '0;
    in_origin_y  <= '0;
    in_scale     <= '0;
    in_red       <= '0;
    in_green     <= '0;
    in_blue      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (glyph_cases[i]) send_char(glyph_cases[i]);

    // hold off until the DUT has drained completely
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_CHARS; i++) begin
      // a quiet stretch in the middle, and none at all toward the end
      idle_on = (i < 60) || (i >= 90 && i < 150);
      send_char(random_char());
    end
    in_valid <= 1'b0;

    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: ends the run with an error if it has not finished by this timeout.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
